@@ design/mas_pkg.sv @@
// Shared constants, types and the seven-segment encoder for the moving average readout.
package mas_pkg;

  // readout shape
  localparam int DIGITS        = 4;
  localparam int SEG_BITS      = 8;
  localparam int SEL_BITS      = 2;
  localparam int DP_DIGIT      = 1;
  localparam int OUT_DATA_BITS = 8;

  localparam logic [SEG_BITS-1:0] DP_BIT = 8'h80;

  // v / 10 as (v * 3277) >> 15, exact for v below 16384
  localparam int DIV10_MUL   = 3277;
  localparam int DIV10_SHIFT = 15;

  // decimal digit codes
  localparam logic [3:0] DIG_0 = 4'd0;
  localparam logic [3:0] DIG_1 = 4'd1;
  localparam logic [3:0] DIG_2 = 4'd2;
  localparam logic [3:0] DIG_3 = 4'd3;
  localparam logic [3:0] DIG_4 = 4'd4;
  localparam logic [3:0] DIG_5 = 4'd5;
  localparam logic [3:0] DIG_6 = 4'd6;
  localparam logic [3:0] DIG_7 = 4'd7;
  localparam logic [3:0] DIG_8 = 4'd8;
  localparam logic [3:0] DIG_9 = 4'd9;

  // one segment pattern per digit, digit 0 in the low byte
  typedef logic [DIGITS-1:0][SEG_BITS-1:0] seg_set_t;

  // segment pattern, bit 6..0 = g..a; six lacks the top bar, nine the bottom bar
  function automatic logic [SEG_BITS-1:0] seg_of(input logic [3:0] digit);
    logic [SEG_BITS-1:0] seg;
    unique case (digit)
      DIG_0:   seg = 8'h3F;
      DIG_1:   seg = 8'h06;
      DIG_2:   seg = 8'h5B;
      DIG_3:   seg = 8'h4F;
      DIG_4:   seg = 8'h66;
      DIG_5:   seg = 8'h6D;
      DIG_6:   seg = 8'h7C;
      DIG_7:   seg = 8'h07;
      DIG_8:   seg = 8'h7F;
      DIG_9:   seg = 8'h67;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

@@ design/mas_window.sv @@
// Sample shift line of window cells and the running sum over the window.
module mas_window import mas_pkg::*; #(
  parameter int WINDOW_DEPTH = 32,
  parameter int SAMPLE_BITS  = 10,
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [SUM_BITS-1:0]    sum_o
);

  logic [SAMPLE_BITS-1:0] tap_r [WINDOW_DEPTH];
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic                   v_r;
  logic                   take;

  // sum_r is the output payload; it only moves when the slot frees
  assign ready_o = !v_r || ready_i;
  assign take    = valid_i && ready_o;
  assign valid_o = v_r;
  assign sum_o   = sum_r;

  // oldest sample leaves at the tail cell
  assign sum_nxt = sum_r - SUM_BITS'(tap_r[WINDOW_DEPTH-1]) + SUM_BITS'(sample_i);

  // head cell takes the new sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r[0] <= '0;
    end else if (take) begin
      tap_r[0] <= sample_i;
    end
  end

  // each cell hands its sample to the next one on every item
  for (genvar i = 1; i < WINDOW_DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tap_r[i] <= '0;
      end else if (take) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  // running sum and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      v_r   <= 1'b0;
    end else begin
      if (take) begin
        sum_r <= sum_nxt;
      end
      if (ready_o) begin
        v_r <= valid_i;
      end
    end
  end

endmodule

@@ design/mas_mean.sv @@
// Three-stage division of the window sum by the window depth (reciprocal multiply + fix-up).
module mas_mean import mas_pkg::*; #(
  parameter int WINDOW_DEPTH = 32,
  parameter int SAMPLE_BITS  = 10,
  localparam int SUM_BITS    = SAMPLE_BITS + $clog2(WINDOW_DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [SUM_BITS-1:0]    sum_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [SAMPLE_BITS-1:0] mean_o
);

  // estimate from floor(2^K / depth) is low by at most one
  localparam int K         = SUM_BITS;
  localparam int PROD_BITS = SUM_BITS + K;
  localparam logic [K-1:0] RECIP = K'((64'd1 << K) / WINDOW_DEPTH);
  localparam logic [SUM_BITS-1:0] DEPTH = SUM_BITS'(WINDOW_DEPTH);

  logic                   v1_r, v2_r, v3_r;
  logic                   rdy1, rdy2, rdy3;
  logic [PROD_BITS-1:0]   prod1_r;
  logic [SUM_BITS-1:0]    sum1_r, sum2_r;
  logic [SAMPLE_BITS-1:0] q2_r, mean3_r;
  logic [SUM_BITS-1:0]    qd2_r;
  logic [SAMPLE_BITS-1:0] q_est;
  logic [SUM_BITS-1:0]    rem;

  assign rdy3    = !v3_r || ready_i;
  assign rdy2    = !v2_r || rdy3;
  assign rdy1    = !v1_r || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_r;
  assign mean_o  = mean3_r;

  assign q_est = prod1_r[K +: SAMPLE_BITS];
  assign rem   = sum2_r - qd2_r;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= valid_i;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // stage 1: sum times reciprocal
  always_ff @(posedge clk) begin
    if (rdy1 && valid_i) begin
      prod1_r <= PROD_BITS'(sum_i) * PROD_BITS'(RECIP);
      sum1_r  <= sum_i;
    end
  end

  // stage 2: quotient estimate and its back product
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      q2_r   <= q_est;
      qd2_r  <= SUM_BITS'(q_est) * DEPTH;
      sum2_r <= sum1_r;
    end
  end

  // stage 3: bump the estimate when the remainder reaches the depth
  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      mean3_r <= q2_r + SAMPLE_BITS'(rem >= DEPTH);
    end
  end

endmodule

@@ design/mas_digit_cell.sv @@
// One decimal digit cell: peels off the low digit, encodes it, passes the quotient on.
module mas_digit_cell import mas_pkg::*; #(
  parameter int VAL_BITS    = 10,
  parameter int DIGIT_INDEX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [VAL_BITS-1:0] value_i,
  input  seg_set_t            segs_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [VAL_BITS-1:0] value_o,
  output seg_set_t            segs_o
);

  localparam int PROD_BITS = VAL_BITS + DIV10_SHIFT;

  logic                v_r;
  logic [VAL_BITS-1:0] value_r;
  seg_set_t            segs_r;
  seg_set_t            segs_nxt;
  logic [PROD_BITS-1:0] prod;
  logic [VAL_BITS-1:0] quot;
  logic [VAL_BITS-1:0] rem;
  logic [SEG_BITS-1:0] seg;

  assign ready_o = !v_r || ready_i;
  assign valid_o = v_r;
  assign value_o = value_r;
  assign segs_o  = segs_r;

  // divide by ten, remainder by shift-add back product
  assign prod = PROD_BITS'(value_i) * PROD_BITS'(DIV10_MUL);
  assign quot = prod[DIV10_SHIFT +: VAL_BITS];
  assign rem  = value_i - ((quot << 3) + (quot << 1));

  // decimal point rides on the tens digit
  always_comb begin
    seg = seg_of(rem[3:0]);
    if (DIGIT_INDEX == DP_DIGIT) begin
      seg = seg | DP_BIT;
    end
  end

  // this cell's pattern goes into its slot of the digit set
  always_comb begin
    segs_nxt              = segs_i;
    segs_nxt[DIGIT_INDEX] = seg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      value_r <= quot;
      segs_r  <= segs_nxt;
    end
  end

endmodule

@@ design/moving_average_seven_segment_readout.sv @@
// Top level: boxcar moving average of converter samples shown as four seven-segment digits.
//
// Input channel in_*: one sample per item, in in_tdata, taken when in_tvalid and in_tready
// are both high. Bits of in_tdata above SAMPLE_BITS are ignored.
// Output channel out_*: four items per sample, least significant digit first. Each carries
// the segment pattern in out_tdata (bit 7 decimal point, set on digit 1 only) and the digit
// select in out_tuser; out_tlast marks the fourth, most significant digit.
// The mean is the window sum divided by WINDOW_DEPTH, truncated; until the window has seen
// WINDOW_DEPTH samples the missing ones count as zero.
// A sample's first digit appears once its item has passed the window sum, three divider
// stages, four digit cells and the output register.
// The output register sends a sample's four digits one per cycle while out_tready is high and
// loads the next sample as the last digit is taken. Up to eight further samples are taken
// into the pipeline while the output waits.
// Reset (rst_n low, synchronous) clears the window cells, the sum and all valid flags; no
// clearing pass is needed afterwards.
// When out_tready is low the current digit holds; the pipeline fills and then in_tready
// drops, and nothing is lost.
module moving_average_seven_segment_readout import mas_pkg::*; #(
  parameter int WINDOW_DEPTH = 32,
  parameter int SAMPLE_BITS  = 10,
  localparam int IN_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // sample
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // segments
  output logic [SEL_BITS-1:0]      out_tuser,  // digit_select
  output logic                     out_tlast
);

  localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam logic [SUM_BITS-1:0] MAX_SUM =
    SUM_BITS'(WINDOW_DEPTH * ((1 << SAMPLE_BITS) - 1));
  localparam logic [SEL_BITS-1:0] LAST_SEL = SEL_BITS'(DIGITS - 1);

  logic                   win_valid, win_ready;
  logic [SUM_BITS-1:0]    win_sum;
  logic                   mean_valid, mean_ready;
  logic [SAMPLE_BITS-1:0] mean;

  logic                   dc_valid [DIGITS+1];
  logic                   dc_ready [DIGITS+1];
  logic [SAMPLE_BITS-1:0] dc_value [DIGITS+1];
  seg_set_t               dc_segs  [DIGITS+1];

  logic                   ser_v_r;
  logic [SEL_BITS-1:0]    ser_cnt_r;
  seg_set_t               ser_segs_r;
  logic                   out_acc, load;

  mas_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .sample_i(in_tdata[SAMPLE_BITS-1:0]),
    .valid_o (win_valid),
    .ready_i (win_ready),
    .sum_o   (win_sum)
  );

  mas_mean #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mean (
    .clk    (clk),
    .rst_n  (rst_n),
    .valid_i(win_valid),
    .ready_o(win_ready),
    .sum_i  (win_sum),
    .valid_o(mean_valid),
    .ready_i(mean_ready),
    .mean_o (mean)
  );

  // chain of digit cells, least significant first
  assign dc_valid[0] = mean_valid;
  assign mean_ready  = dc_ready[0];
  assign dc_value[0] = mean;
  assign dc_segs[0]  = '0;

  for (genvar k = 0; k < DIGITS; k++) begin : g_digit
    mas_digit_cell #(
      .VAL_BITS   (SAMPLE_BITS),
      .DIGIT_INDEX(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .valid_i(dc_valid[k]),
      .ready_o(dc_ready[k]),
      .value_i(dc_value[k]),
      .segs_i (dc_segs[k]),
      .valid_o(dc_valid[k+1]),
      .ready_i(dc_ready[k+1]),
      .value_o(dc_value[k+1]),
      .segs_o (dc_segs[k+1])
    );
  end

  // output register: sends the four digits one per item
  assign out_acc          = out_tvalid && out_tready;
  assign dc_ready[DIGITS] = !ser_v_r || (out_tready && ser_cnt_r == LAST_SEL);
  assign load             = dc_valid[DIGITS] && dc_ready[DIGITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r   <= 1'b0;
      ser_cnt_r <= '0;
    end else begin
      if (out_acc) begin
        ser_cnt_r <= (ser_cnt_r == LAST_SEL) ? '0 : ser_cnt_r + 1'b1;
      end
      if (load) begin
        ser_v_r <= 1'b1;
      end else if (out_acc && ser_cnt_r == LAST_SEL) begin
        ser_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser_segs_r <= dc_segs[DIGITS];
    end
  end

  assign out_tvalid = ser_v_r;
  assign out_tdata  = ser_segs_r[ser_cnt_r];
  assign out_tuser  = ser_cnt_r;
  assign out_tlast  = (ser_cnt_r == LAST_SEL);

  // a sample's digits go out without a gap in validity
  a_digits_continue: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_tlast |=> out_tvalid)
    else $error("digit run broken before the last digit");

  // digit select steps by one within a run
  a_select_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && !out_tlast |=> ser_cnt_r == $past(ser_cnt_r) + 1'b1)
    else $error("digit select did not advance");

  // decimal point only on the tens digit
  a_dp_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[SEG_BITS-1] == (ser_cnt_r == SEL_BITS'(DP_DIGIT))))
    else $error("decimal point on wrong digit");

  // window sum never exceeds a full window of maximum samples
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    win_sum <= MAX_SUM)
    else $error("running sum out of range");

endmodule
